// File: rtl/clps_pkg.sv
// Shared types, codes and constants of the cone light pixel shader.
`timescale 1ns / 1ps
`default_nettype none

package clps_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_INTENSITY = 3'd0,
		CFG_AMBIENT   = 3'd1,
		CFG_FLICKER   = 3'd2,
		CFG_FACING    = 3'd3,
		CFG_LIGHT_COL = 3'd4,
		CFG_LIGHT_ROW = 3'd5,
		CFG_MASK      = 3'd6
	} cfg_idx_e;

	// Cone facing codes
	typedef enum logic [1:0] {
		FACE_EAST  = 2'd0,
		FACE_WEST  = 2'd1,
		FACE_NORTH = 2'd2,
		FACE_SOUTH = 2'd3
	} dir_e;

	// Item command codes
	typedef enum logic {
		CMD_SHADE = 1'b0,
		CMD_LOAD  = 1'b1
	} cmd_e;

	localparam int DEFAULT_TABLE_RADIUS = 127;

	localparam logic [8:0]  UNITY      = 9'd256;
	localparam logic [7:0]  ALPHA      = 8'hFF;
	localparam logic [7:0]  ROUND_HALF = 8'd128;
	localparam logic [15:0] PCT_RECIP  = 16'd41944;   // ceil(2^22 / 100)

	// Register reset values
	localparam int RST_INTENSITY = 85;
	localparam int RST_AMBIENT   = 25;
	localparam int RST_FLICKER   = 256;
	localparam int RST_I256      = RST_INTENSITY * 256 / 100;
	localparam int RST_AMB       = RST_AMBIENT * 256 / 100;
	localparam int RST_K         = RST_I256 * RST_FLICKER / 256;

	// Light terms derived from the configuration registers
	typedef struct packed {
		logic [8:0] k;         // intensity term, 0..256
		logic [8:0] amb;       // ambient floor, 0..256
		logic [8:0] amb_inv;   // 256 - ambient floor
		logic       mask;      // grey mask output
	} terms_t;

	// Shade item sideband travelling beside the table access
	typedef struct packed {
		logic        valid;
		logic        hit;      // offset lies inside the table radius
		logic [23:0] rgb;
	} shade_t;

	// pct * 256 / 100, truncated, by reciprocal multiplication (exact for 7-bit pct)
	function automatic logic [8:0] pct_to_q8(input logic [6:0] pct);
		logic [30:0] prod;
		begin
			prod = 31'({pct, 8'b0}) * 31'(PCT_RECIP);
			return prod[30:22];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/clps_geom.sv
// Offset, rotation and table addressing stages of the cone light shader.
`timescale 1ns / 1ps
`default_nettype none

module clps_geom #(
	parameter int TABLE_RADIUS = clps_pkg::DEFAULT_TABLE_RADIUS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                item_take,
	input  wire logic                command,
	input  wire logic [8:0]          pixel_x,
	input  wire logic [7:0]          pixel_y,
	input  wire logic [23:0]         pixel_rgb,
	input  wire logic [7:0]          table_side,
	input  wire logic [7:0]          table_forward,
	input  wire logic [7:0]          table_value,
	input  wire clps_pkg::dir_e      facing,
	input  wire logic signed [9:0]   light_col,
	input  wire logic signed [8:0]   light_row,
	output logic                     wr_en,
	output logic [$clog2((2*TABLE_RADIUS+1)*(2*TABLE_RADIUS+1))-1:0] addr,
	output logic [7:0]               wdata,
	output clps_pkg::shade_t         shade
);

	localparam int TSIZE = 2 * TABLE_RADIUS + 1;
	localparam int IW    = $clog2(TSIZE);
	localparam int AW    = $clog2(TSIZE * TSIZE);
	localparam logic signed [11:0] RAD = 12'(TABLE_RADIUS);

	logic signed [11:0] dx, dy, fwd_n, side_n;
	logic               sv_s1, ld_s1;
	logic signed [11:0] fwd_s1, side_s1;
	logic [23:0]        rgb_s1;
	logic [7:0]         tside_s1, tfwd_s1, tval_s1;

	logic               hit, ld_ok;
	logic signed [11:0] fwd_off, side_off;
	logic [IW-1:0]      row, col;
	logic [AW-1:0]      addr_n;

	logic               sv_s2, wr_s2, hit_s2;
	logic [AW-1:0]      addr_s2;
	logic [7:0]         wdata_s2;
	logic [23:0]        rgb_s2;

	// offset from the anchor, rotated into forward and side
	always_comb begin
		dx = $signed({3'b000, pixel_x}) - $signed({{2{light_col[9]}}, light_col});
		dy = $signed({4'b0000, pixel_y}) - $signed({{3{light_row[8]}}, light_row});
		case (facing)
			clps_pkg::FACE_WEST: begin
				fwd_n  = -dx;
				side_n = dy;
			end
			clps_pkg::FACE_NORTH: begin
				fwd_n  = -dy;
				side_n = dx;
			end
			clps_pkg::FACE_SOUTH: begin
				fwd_n  = dy;
				side_n = dx;
			end
			default: begin
				fwd_n  = dx;
				side_n = dy;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s1 <= 1'b0;
			ld_s1 <= 1'b0;
		end else if (adv) begin
			sv_s1 <= item_take && (command == clps_pkg::CMD_SHADE);
			ld_s1 <= item_take && (command == clps_pkg::CMD_LOAD);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_s1   <= fwd_n;
			side_s1  <= side_n;
			rgb_s1   <= pixel_rgb;
			tside_s1 <= table_side;
			tfwd_s1  <= table_forward;
			tval_s1  <= table_value;
		end
	end

	// range check and row-major table address
	always_comb begin
		hit      = (fwd_s1 >= -RAD) && (fwd_s1 <= RAD) && (side_s1 >= -RAD) && (side_s1 <= RAD);
		ld_ok    = (32'(tside_s1) < TSIZE) && (32'(tfwd_s1) < TSIZE);
		fwd_off  = fwd_s1 + RAD;
		side_off = side_s1 + RAD;
		if (ld_s1) begin
			row = IW'(tside_s1);
			col = IW'(tfwd_s1);
		end else if (hit) begin
			row = side_off[IW-1:0];
			col = fwd_off[IW-1:0];
		end else begin
			row = '0;
			col = '0;
		end
		if (ld_s1 && !ld_ok) begin
			row = '0;
			col = '0;
		end
		addr_n = (AW'(row) * AW'(TSIZE)) + AW'(col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s2 <= 1'b0;
			wr_s2 <= 1'b0;
		end else if (adv) begin
			sv_s2 <= sv_s1;
			wr_s2 <= ld_s1 && ld_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s2  <= addr_n;
			wdata_s2 <= tval_s1;
			hit_s2   <= hit;
			rgb_s2   <= rgb_s1;
		end
	end

	assign wr_en = wr_s2;
	assign addr  = addr_s2;
	assign wdata = wdata_s2;
	assign shade = {sv_s2, hit_s2, rgb_s2};

endmodule

`default_nettype wire

// File: rtl/clps_table.sv
// Falloff table memory of the cone light shader, one access per advancing cycle.
`timescale 1ns / 1ps
`default_nettype none

module clps_table #(
	parameter int TABLE_RADIUS = clps_pkg::DEFAULT_TABLE_RADIUS
) (
	input  wire logic       clk,
	input  wire logic       adv,
	input  wire logic       wr_en,
	input  wire logic [$clog2((2*TABLE_RADIUS+1)*(2*TABLE_RADIUS+1))-1:0] addr,
	input  wire logic [7:0] wdata,
	output logic      [7:0] rdata
);

	localparam int DEPTH = (2 * TABLE_RADIUS + 1) * (2 * TABLE_RADIUS + 1);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// hold the read data while the pipeline is stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_en) begin
				mem[addr] <= wdata;
			end
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/clps_mix.sv
// Light mixing and channel scaling stages of the cone light shader.
`timescale 1ns / 1ps
`default_nettype none

module clps_mix (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire clps_pkg::shade_t shade,
	input  wire logic [7:0]       rdata,
	input  wire clps_pkg::terms_t terms,
	output logic                  result_valid,
	output logic [31:0]           pixel_out
);

	logic        sv_s3, hit_s3;
	logic [23:0] rgb_s3;
	logic [7:0]  lv;

	logic        sv_s4;
	logic [23:0] rgb_s4;
	logic [16:0] prod_s4;

	logic [25:0] scaled;
	logic [10:0] sum;
	logic        sv_s5;
	logic [23:0] rgb_s5;
	logic [8:0]  total_s5;

	logic [15:0] grey_sum;
	logic [16:0] r_prod, g_prod, b_prod;
	logic [31:0] pix_n;
	logic        valid_q;
	logic [31:0] pixel_q;

	// s3: sideband beside the table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s3 <= 1'b0;
		end else if (adv) begin
			sv_s3 <= shade.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s3 <= shade.hit;
			rgb_s3 <= shade.rgb;
		end
	end

	assign lv = hit_s3 ? rdata : 8'd0;

	// s4: table byte times intensity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s4 <= 1'b0;
		end else if (adv) begin
			sv_s4 <= sv_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= 17'(lv) * 17'(terms.k);
			rgb_s4  <= rgb_s3;
		end
	end

	// s5: scale by the headroom above ambient and add the floor
	always_comb begin
		scaled = 26'(prod_s4) * 26'(terms.amb_inv);
		sum    = 11'(terms.amb) + 11'(scaled[25:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s5 <= 1'b0;
		end else if (adv) begin
			sv_s5 <= sv_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			total_s5 <= (sum > 11'(clps_pkg::UNITY)) ? clps_pkg::UNITY : sum[8:0];
			rgb_s5   <= rgb_s4;
		end
	end

	// s6: grey level or per-channel scaling
	always_comb begin
		grey_sum = (16'(total_s5) * 16'd255) + 16'(clps_pkg::ROUND_HALF);
		r_prod   = 17'(rgb_s5[23:16]) * 17'(total_s5);
		g_prod   = 17'(rgb_s5[15:8]) * 17'(total_s5);
		b_prod   = 17'(rgb_s5[7:0]) * 17'(total_s5);
		if (terms.mask) begin
			pix_n = {clps_pkg::ALPHA, grey_sum[15:8], grey_sum[15:8], grey_sum[15:8]};
		end else begin
			pix_n = {clps_pkg::ALPHA, r_prod[15:8], g_prod[15:8], b_prod[15:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= sv_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_q <= pix_n;
		end
	end

	assign result_valid = valid_q;
	assign pixel_out    = pixel_q;

endmodule

`default_nettype wire

// File: rtl/cone_light_pixel_shader.sv
// Top level of the cone light pixel shader: configuration, pipeline control and stages.
//
// Usage:
//   Item channel (item_valid / item_stall): command 1 loads one falloff table entry
//   at (table_side, table_forward); command 0 shades one pixel at (pixel_x, pixel_y).
//   Load every table entry that shading will read before sending shade items.
//   Result channel (result_valid / result_stall): one ARGB pixel_out per shade item,
//   none per load item, in item order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is always
//   high; write only while the pipeline is empty, and leave two cycles before the
//   next item so that the derived light terms settle. Unknown indexes are dropped.
//   Throughput: one item per clock while no result is stalled. Each item passes
//   six register stages (offset, address, table read, intensity product,
//   ambient mix, channel scaling). The table read is a single-port memory access.
//   Reset: control and configuration return to their defaults; the falloff table
//   is not cleared and holds nothing valid until loaded.
//   Stall: a stalled result freezes the whole pipeline, and item_stall rises in the
//   same cycle; nothing is dropped or repeated, and bubbles are not squeezed out.
`timescale 1ns / 1ps
`default_nettype none

module cone_light_pixel_shader #(
	parameter int TABLE_RADIUS = clps_pkg::DEFAULT_TABLE_RADIUS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        command,
	input  wire logic [8:0]  pixel_x,
	input  wire logic [7:0]  pixel_y,
	input  wire logic [23:0] pixel_rgb,
	input  wire logic [7:0]  table_side,
	input  wire logic [7:0]  table_forward,
	input  wire logic [7:0]  table_value,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [31:0]      pixel_out,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);

	localparam int AW = $clog2((2 * TABLE_RADIUS + 1) * (2 * TABLE_RADIUS + 1));

	// configuration registers
	logic [6:0]         intensity_q;
	logic [6:0]         ambient_q;
	logic [8:0]         flicker_q;
	clps_pkg::dir_e     facing_q;
	logic signed [9:0]  light_col_q;
	logic signed [8:0]  light_row_q;
	logic               mask_q;

	// derived light terms
	logic [8:0]         i256_q;
	logic [8:0]         amb_raw;
	logic [8:0]         amb_n;
	logic [17:0]        kprod;
	logic [8:0]         k_n;
	clps_pkg::terms_t   terms_q;

	// pipeline
	logic               adv;
	logic               item_take;
	logic               wr_en;
	logic [AW-1:0]      addr;
	logic [7:0]         wdata;
	logic [7:0]         rdata;
	clps_pkg::shade_t   shade;

	// the whole pipeline advances unless a finished result is held by the receiver
	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;
	assign item_take  = item_valid && adv;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q <= 7'(clps_pkg::RST_INTENSITY);
			ambient_q   <= 7'(clps_pkg::RST_AMBIENT);
			flicker_q   <= 9'(clps_pkg::RST_FLICKER);
			facing_q    <= clps_pkg::FACE_SOUTH;
			light_col_q <= '0;
			light_row_q <= '0;
			mask_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (clps_pkg::cfg_idx_e'(cfg_index))
				clps_pkg::CFG_INTENSITY: intensity_q <= cfg_data[6:0];
				clps_pkg::CFG_AMBIENT:   ambient_q   <= cfg_data[6:0];
				clps_pkg::CFG_FLICKER:   flicker_q   <= cfg_data[8:0];
				clps_pkg::CFG_FACING:    facing_q    <= clps_pkg::dir_e'(cfg_data[1:0]);
				clps_pkg::CFG_LIGHT_COL: light_col_q <= cfg_data[9:0];
				clps_pkg::CFG_LIGHT_ROW: light_row_q <= cfg_data[8:0];
				clps_pkg::CFG_MASK:      mask_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// percentages to 1/256 units; ambient saturates at unity
	always_comb begin
		amb_raw = clps_pkg::pct_to_q8(ambient_q);
		amb_n   = (amb_raw > clps_pkg::UNITY) ? clps_pkg::UNITY : amb_raw;
		kprod   = 18'(i256_q) * 18'(flicker_q);
		// mask mode ignores the flicker
		if (mask_q) begin
			k_n = (i256_q > clps_pkg::UNITY) ? clps_pkg::UNITY : i256_q;
		end else begin
			k_n = (kprod[17:8] > 10'(clps_pkg::UNITY)) ? clps_pkg::UNITY : kprod[16:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i256_q          <= 9'(clps_pkg::RST_I256);
			terms_q.k       <= 9'(clps_pkg::RST_K);
			terms_q.amb     <= 9'(clps_pkg::RST_AMB);
			terms_q.amb_inv <= clps_pkg::UNITY - 9'(clps_pkg::RST_AMB);
			terms_q.mask    <= 1'b0;
		end else begin
			i256_q          <= clps_pkg::pct_to_q8(intensity_q);
			terms_q.k       <= k_n;
			terms_q.amb     <= amb_n;
			terms_q.amb_inv <= clps_pkg::UNITY - amb_n;
			terms_q.mask    <= mask_q;
		end
	end

	// stages 1 and 2: offset, rotation, range check and table address
	clps_geom #(
		.TABLE_RADIUS(TABLE_RADIUS)
	) u_geom (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.item_take     (item_take),
		.command       (command),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_rgb     (pixel_rgb),
		.table_side    (table_side),
		.table_forward (table_forward),
		.table_value   (table_value),
		.facing        (facing_q),
		.light_col     (light_col_q),
		.light_row     (light_row_q),
		.wr_en         (wr_en),
		.addr          (addr),
		.wdata         (wdata),
		.shade         (shade)
	);

	// stage 3: table write or read; a load always reaches the memory before any shade
	// item behind it reads it, so the read sees the new byte
	clps_table #(
		.TABLE_RADIUS(TABLE_RADIUS)
	) u_table (
		.clk   (clk),
		.adv   (adv),
		.wr_en (wr_en),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// stages 4 to 6: intensity, ambient mix and channel scaling
	clps_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.shade        (shade),
		.rdata        (rdata),
		.terms        (terms_q),
		.result_valid (result_valid),
		.pixel_out    (pixel_out)
	);

endmodule

`default_nettype wire
